// ===== sv/pfpw_pkg.sv =====
package pfpw_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_SAMPLES  = 1024;
  localparam int ADDR_BITS    = $clog2(MAX_SAMPLES);
  localparam int CNT_BITS     = $clog2(MAX_SAMPLES + 1);
  localparam int INDEX_BITS   = 10;
  localparam int MAX_RESULTS  = 11;
  localparam int K_BITS       = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int HEIGHT_BITS   = 16;
  localparam int WIDTH_BITS    = 11;
  localparam int PROM_BITS     = 16;
  localparam int SPACING_BITS  = 10;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [ADDR_BITS-1:0]     addr_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;
  typedef logic [K_BITS-1:0]        kcnt_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_MIN_HEIGHT     = 2'd0;
  localparam cfg_idx_t CFG_MIN_WIDTH      = 2'd1;
  localparam cfg_idx_t CFG_MIN_PROMINENCE = 2'd2;
  localparam cfg_idx_t CFG_MIN_SPACING    = 2'd3;

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 10'd100;

endpackage

// ===== sv/peak_finder_prominence_width.sv =====
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// in       | in_valid, in_ready, in_sample_value, in_row_end | request in
// out      | out_valid, out_ready, out_peak_index,        | request out
//          | out_peak_valid, out_list_end                 |
// cfg      | cfg_wr_en, cfg_index, cfg_data               | write only
//
// Loading accepts one sample per cycle; the row sits in a 1024 x 16 sample RAM
// with one write and one registered read port, and that read port sets the scan
// time. Each index passes through S_NEXT, S_EVAL and S_ADV; a candidate adds
// the left walk (S_WL), the right walk (S_WRS, S_WR) and S_DECIDE. Reset
// clears control state and the configuration registers, not the datapath; the
// sample RAM is not cleared since every entry is written before it is read.
// A full output register stalls the scan when a kept peak must be handed over
// or the list closed; the next row may load while the final result still waits.
module peak_finder_prominence_width (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input samples
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pfpw_pkg::SAMPLE_BITS-1:0]     in_sample_value,
  input  logic                                 in_row_end,
  // peak list
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pfpw_pkg::INDEX_BITS-1:0]      out_peak_index,
  output logic                                 out_peak_valid,
  output logic                                 out_list_end,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [pfpw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pfpw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // Sequencer codes
  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_RD1    = 4'd2;
  localparam logic [3:0] S_RD2    = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_WL     = 4'd6;
  localparam logic [3:0] S_WRS    = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_DECIDE = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;
  localparam logic [3:0] S_ADV    = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  // Configuration registers
  logic [pfpw_pkg::HEIGHT_BITS-1:0]  min_height_r;
  logic [pfpw_pkg::WIDTH_BITS-1:0]   min_width_r;
  logic [pfpw_pkg::PROM_BITS-1:0]    min_prom_r;
  logic [pfpw_pkg::SPACING_BITS-1:0] min_spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_height_r  <= '0;
      min_width_r   <= '0;
      min_prom_r    <= '0;
      min_spacing_r <= pfpw_pkg::SPACING_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pfpw_pkg::CFG_MIN_HEIGHT:     min_height_r  <= cfg_data[pfpw_pkg::HEIGHT_BITS-1:0];
        pfpw_pkg::CFG_MIN_WIDTH:      min_width_r   <= cfg_data[pfpw_pkg::WIDTH_BITS-1:0];
        pfpw_pkg::CFG_MIN_PROMINENCE: min_prom_r    <= cfg_data[pfpw_pkg::PROM_BITS-1:0];
        pfpw_pkg::CFG_MIN_SPACING:    min_spacing_r <= cfg_data[pfpw_pkg::SPACING_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and scan registers
  logic [3:0]             state_r, state_nxt;
  pfpw_pkg::cnt_t         cnt_r, cnt_nxt;
  pfpw_pkg::addr_t        i_r, i_nxt;
  pfpw_pkg::addr_t        lo_r, lo_nxt;
  pfpw_pkg::addr_t        hi_r, hi_nxt;
  pfpw_pkg::sample_t      prev_r, prev_nxt;
  pfpw_pkg::sample_t      cur_r, cur_nxt;
  pfpw_pkg::sample_t      next_r, next_nxt;
  pfpw_pkg::sample_t      lo_val_r, lo_val_nxt;
  pfpw_pkg::sample_t      hi_val_r, hi_val_nxt;
  pfpw_pkg::addr_t        last_r, last_nxt;
  logic                   have_r, have_nxt;
  pfpw_pkg::addr_t        pend_r, pend_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  pfpw_pkg::kcnt_t        k_r, k_nxt;

  // Output register
  logic                                  out_valid_r, out_valid_nxt;
  logic [pfpw_pkg::INDEX_BITS-1:0]       out_idx_r, out_idx_nxt;
  logic                                  out_pv_r, out_pv_nxt;
  logic                                  out_end_r, out_end_nxt;

  // Sample RAM
  pfpw_pkg::sample_t mem [pfpw_pkg::MAX_SAMPLES];
  pfpw_pkg::sample_t rd_data_r;
  pfpw_pkg::addr_t   rd_addr;
  logic              rd_en;
  logic              wr_en;

  logic              in_acc;
  logic              slot_free;
  pfpw_pkg::cnt_t    i_ext;
  pfpw_pkg::cnt_t    hi_ext;
  logic              cand;
  pfpw_pkg::sample_t flank_max;
  pfpw_pkg::addr_t   width_v;
  pfpw_pkg::sample_t prom_v;
  pfpw_pkg::addr_t   gap_v;
  logic              keep;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (cnt_r < pfpw_pkg::cnt_t'(pfpw_pkg::MAX_SAMPLES));
  assign slot_free = !out_valid_r || out_ready;

  assign i_ext  = pfpw_pkg::cnt_t'(i_r);
  assign hi_ext = pfpw_pkg::cnt_t'(hi_r);

  // Candidate test on the sample window
  assign cand = (cur_r > pfpw_pkg::sample_t'(min_height_r)) && (cur_r > prev_r) &&
                (cur_r >= next_r);

  // Width, prominence and spacing tests
  assign flank_max = (lo_val_r > hi_val_r) ? lo_val_r : hi_val_r;
  assign width_v   = hi_r - lo_r;
  assign prom_v    = cur_r - flank_max;
  assign gap_v     = i_r - last_r;
  assign keep      = ({1'b0, width_v} >= min_width_r) &&
                     (prom_v > pfpw_pkg::sample_t'(min_prom_r)) &&
                     (!have_r || (gap_v > min_spacing_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[pfpw_pkg::ADDR_BITS-1:0]] <= in_sample_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    lo_val_nxt    = lo_val_r;
    hi_val_nxt    = hi_val_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    k_nxt         = k_r;
    out_idx_nxt   = out_idx_r;
    out_pv_nxt    = out_pv_r;
    out_end_nxt   = out_end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_LOAD: begin
        // Store samples until the row ends; drop those beyond the RAM depth
        if (wr_en) begin
          cnt_nxt = cnt_r + pfpw_pkg::cnt_t'(1);
        end
        if (in_acc && in_row_end) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (cnt_r < pfpw_pkg::cnt_t'(3)) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pfpw_pkg::addr_t'(0);
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        prev_nxt  = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = pfpw_pkg::addr_t'(1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cur_nxt   = rd_data_r;
        i_nxt     = pfpw_pkg::addr_t'(1);
        rd_en     = 1'b1;
        rd_addr   = pfpw_pkg::addr_t'(2);
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        next_nxt  = rd_data_r;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (cand) begin
          lo_nxt     = i_r - pfpw_pkg::addr_t'(1);
          lo_val_nxt = prev_r;
          if (i_r > pfpw_pkg::addr_t'(1)) begin
            rd_en     = 1'b1;
            rd_addr   = i_r - pfpw_pkg::addr_t'(2);
            state_nxt = S_WL;
          end else begin
            state_nxt = S_WRS;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_WL: begin
        // Walk left over samples that do not rise
        if (rd_data_r <= lo_val_r) begin
          lo_nxt     = lo_r - pfpw_pkg::addr_t'(1);
          lo_val_nxt = rd_data_r;
          if (lo_r > pfpw_pkg::addr_t'(1)) begin
            rd_en   = 1'b1;
            rd_addr = lo_r - pfpw_pkg::addr_t'(2);
          end else begin
            state_nxt = S_WRS;
          end
        end else begin
          state_nxt = S_WRS;
        end
      end
      S_WRS: begin
        hi_nxt     = i_r + pfpw_pkg::addr_t'(1);
        hi_val_nxt = next_r;
        if ((i_ext + pfpw_pkg::cnt_t'(2)) < cnt_r) begin
          rd_en     = 1'b1;
          rd_addr   = i_r + pfpw_pkg::addr_t'(2);
          state_nxt = S_WR;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_WR: begin
        // Walk right over samples that do not rise
        if (rd_data_r <= hi_val_r) begin
          hi_nxt     = hi_r + pfpw_pkg::addr_t'(1);
          hi_val_nxt = rd_data_r;
          if ((hi_ext + pfpw_pkg::cnt_t'(2)) < cnt_r) begin
            rd_en   = 1'b1;
            rd_addr = hi_r + pfpw_pkg::addr_t'(2);
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (keep) begin
          last_nxt = i_r;
          have_nxt = 1'b1;
          k_nxt    = k_r + pfpw_pkg::kcnt_t'(1);
          if (pend_vld_r) begin
            state_nxt = S_PUSH;
          end else begin
            pend_nxt     = i_r;
            pend_vld_nxt = 1'b1;
            state_nxt    = (k_r + pfpw_pkg::kcnt_t'(1) == pfpw_pkg::kcnt_t'(pfpw_pkg::MAX_RESULTS))
                           ? S_FIN : S_ADV;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_PUSH: begin
        // Hand over the held peak; it is not the last one
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = pend_r;
          out_pv_nxt    = 1'b1;
          out_end_nxt   = 1'b0;
          pend_nxt      = i_r;
          state_nxt     = (k_r == pfpw_pkg::kcnt_t'(pfpw_pkg::MAX_RESULTS)) ? S_FIN : S_ADV;
        end
      end
      S_ADV: begin
        // Slide the window one sample right
        if ((i_ext + pfpw_pkg::cnt_t'(2)) < cnt_r) begin
          prev_nxt  = cur_r;
          cur_nxt   = next_r;
          i_nxt     = i_r + pfpw_pkg::addr_t'(1);
          rd_en     = 1'b1;
          rd_addr   = i_r + pfpw_pkg::addr_t'(2);
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Close the list: the held peak, or an empty marker
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = pend_vld_r ? pend_r : '0;
          out_pv_nxt    = pend_vld_r;
          out_end_nxt   = 1'b1;
          cnt_nxt       = '0;
          last_nxt      = '0;
          have_nxt      = 1'b0;
          pend_vld_nxt  = 1'b0;
          k_nxt         = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      last_r      <= '0;
      have_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      have_r      <= have_nxt;
      pend_vld_r  <= pend_vld_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    next_r    <= next_nxt;
    lo_val_r  <= lo_val_nxt;
    hi_val_r  <= hi_val_nxt;
    pend_r    <= pend_nxt;
    out_idx_r <= out_idx_nxt;
    out_pv_r  <= out_pv_nxt;
    out_end_r <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_peak_index = out_idx_r;
  assign out_peak_valid = out_pv_r;
  assign out_list_end   = out_end_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pfpw_pkg::cnt_t'(pfpw_pkg::MAX_SAMPLES))
    else $error("sample count beyond RAM depth");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= pfpw_pkg::kcnt_t'(pfpw_pkg::MAX_RESULTS))
    else $error("kept peak count beyond limit");

  a_left_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WL) |-> (lo_r != '0))
    else $error("left walk past row start");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && slot_free) |=> (state_r == S_LOAD && cnt_r == '0 &&
      out_valid_r && out_end_r))
    else $error("row close did not reset scan state");

endmodule

// ===== dv/peak_list_checker.sv =====
module peak_list_checker (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  input  logic                                         in_ready,
  input  pfpw_pkg::sample_t                            in_sample_value,
  input  logic                                         in_row_end,
  input  logic                                         out_valid,
  input  logic                                         out_ready,
  input  logic [pfpw_pkg::INDEX_BITS-1:0]              out_peak_index,
  input  logic                                         out_peak_valid,
  input  logic                                         out_list_end,
  input  logic                                         cfg_wr_en,
  input  pfpw_pkg::cfg_idx_t                           cfg_index,
  input  logic [pfpw_pkg::CFG_DATA_BITS-1:0]           cfg_data,
  output int                                           fail_count,
  output int                                           pending
);

  typedef struct packed {
    logic [pfpw_pkg::INDEX_BITS-1:0] idx;
    logic                            hit;
    logic                            tail;
  } peak_rec_t;

  pfpw_pkg::sample_t                 row_buf [pfpw_pkg::MAX_SAMPLES];
  int unsigned                       row_len;
  logic [pfpw_pkg::HEIGHT_BITS-1:0]  thr_height;
  logic [pfpw_pkg::WIDTH_BITS-1:0]   thr_width;
  logic [pfpw_pkg::PROM_BITS-1:0]    thr_prom;
  logic [pfpw_pkg::SPACING_BITS-1:0] thr_spacing;
  peak_rec_t                         peaks_due [$];
  peak_rec_t                         got;
  peak_rec_t                         want;

  // Scan the stored row and queue the peak list it yields.
  task automatic find_kept_peaks();
    peak_rec_t         found [$];
    peak_rec_t         rec;
    pfpw_pkg::sample_t v;
    pfpw_pkg::sample_t floor_v;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       last_kept;
    logic              have_kept;
    have_kept = 1'b0;
    last_kept = 0;
    for (int unsigned i = 1; i + 1 < row_len && found.size() < pfpw_pkg::MAX_RESULTS; i++) begin
      v = row_buf[i];
      if (v > thr_height && v > row_buf[i-1] && v >= row_buf[i+1]) begin
        lo = i - 1;
        while (lo > 0 && row_buf[lo-1] <= row_buf[lo]) lo--;
        hi = i + 1;
        while (hi + 1 < row_len && row_buf[hi+1] <= row_buf[hi]) hi++;
        floor_v = (row_buf[lo] > row_buf[hi]) ? row_buf[lo] : row_buf[hi];
        if (hi - lo >= thr_width && pfpw_pkg::sample_t'(v - floor_v) > thr_prom &&
            (!have_kept || i - last_kept > thr_spacing)) begin
          rec.idx  = pfpw_pkg::INDEX_BITS'(i);
          rec.hit  = 1'b1;
          rec.tail = 1'b0;
          found    = {found, rec};
          have_kept = 1'b1;
          last_kept = i;
        end
      end
    end
    if (found.size() == 0) begin
      rec.idx  = '0;
      rec.hit  = 1'b0;
      rec.tail = 1'b1;
      found    = {found, rec};
    end else begin
      rec = found.pop_back();
      rec.tail = 1'b1;
      found    = {found, rec};
    end
    foreach (found[j]) peaks_due = {peaks_due, found[j]};
    row_len = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_height  = '0;
      thr_width   = '0;
      thr_prom    = '0;
      thr_spacing = pfpw_pkg::SPACING_RESET;
      row_len     = 0;
      fail_count  = 0;
      peaks_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pfpw_pkg::CFG_MIN_HEIGHT:     thr_height  = cfg_data[pfpw_pkg::HEIGHT_BITS-1:0];
          pfpw_pkg::CFG_MIN_WIDTH:      thr_width   = cfg_data[pfpw_pkg::WIDTH_BITS-1:0];
          pfpw_pkg::CFG_MIN_PROMINENCE: thr_prom    = cfg_data[pfpw_pkg::PROM_BITS-1:0];
          pfpw_pkg::CFG_MIN_SPACING:    thr_spacing = cfg_data[pfpw_pkg::SPACING_BITS-1:0];
          default: ;
        endcase
      end
      // Retire against the queue before a row end on this edge adds to it.
      if (out_valid && out_ready) begin
        got.idx  = out_peak_index;
        got.hit  = out_peak_valid;
        got.tail = out_list_end;
        if (peaks_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: peak result with none pending: index %0d valid %0b end %0b",
                     $time, got.idx, got.hit, got.tail);
        end else begin
          want = peaks_due.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: peak mismatch: want index %0d valid %0b end %0b, ",
                        "got index %0d valid %0b end %0b"}, $time,
                       want.idx, want.hit, want.tail, got.idx, got.hit, got.tail);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (row_len < pfpw_pkg::MAX_SAMPLES) begin
          row_buf[row_len] = in_sample_value;
          row_len++;
        end
        if (in_row_end) find_kept_peaks();
      end
    end
    pending = peaks_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  // Run timing. The long hold outlasts the block's buffering so the input stalls;
  // the watchdog covers a full 1024-sample scan with many candidate walks.
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 30000;

  typedef enum int { SHAPE_HILLS, SHAPE_ZIGZAG, SHAPE_LEVELS, SHAPE_NOISE } row_shape_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  pfpw_pkg::sample_t                   in_sample_value;
  logic                                in_row_end;
  logic                                out_valid;
  logic                                out_ready;
  logic [pfpw_pkg::INDEX_BITS-1:0]     out_peak_index;
  logic                                out_peak_valid;
  logic                                out_list_end;
  logic                                cfg_wr_en;
  pfpw_pkg::cfg_idx_t                  cfg_index;
  logic [pfpw_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  int                        fail_count;
  int                        pending;
  int unsigned               send_idle_pct;
  int unsigned               recv_stall_pct;
  int                        hold_req;
  int                        hold_done;
  int                        quiet_cycles;

  peak_finder_prominence_width i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_index  (out_peak_index),
    .out_peak_valid  (out_peak_valid),
    .out_list_end    (out_list_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  peak_list_checker i_peak_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_index  (out_peak_index),
    .out_peak_valid  (out_peak_valid),
    .out_list_end    (out_list_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at the current rate, or hold off for a long stretch when
  // the sequence asks for one. Only this process writes out_ready and hold_done.
  initial begin
    out_ready = 1'b0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= hold_done + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no request moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one sample request. Call at a rising edge; return at the edge that
  // accepts it. Ready is looked at on the falling edge, where nothing moves.
  task automatic send_sample(input pfpw_pkg::sample_t value, input logic row_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_row_end      <= row_end;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Send one row with random content of the given shape; the last sample ends it.
  task automatic send_row(input int unsigned len, input row_shape_t shape);
    int unsigned       level;
    int unsigned       step;
    pfpw_pkg::sample_t s;
    level = $urandom_range(65535);
    for (int unsigned k = 0; k < len; k++) begin
      case (shape)
        SHAPE_NOISE:  s = pfpw_pkg::sample_t'($urandom());
        // Few levels give plateaus and equal neighbors.
        SHAPE_LEVELS: s = pfpw_pkg::sample_t'($urandom_range(7));
        // Alternate low and high: a peak at every odd index.
        SHAPE_ZIGZAG: s = (k % 2 == 1) ? pfpw_pkg::sample_t'($urandom_range(65535, 1000))
                                       : pfpw_pkg::sample_t'($urandom_range(999));
        default: begin
          // Bounded random walk: broad hills with long flanks to walk.
          step = $urandom_range(4000);
          if ($urandom_range(1) == 1)
            level = (level + step > 65535) ? 65535 : level + step;
          else
            level = (level < step) ? 0 : level - step;
          s = pfpw_pkg::sample_t'(level);
        end
      endcase
      send_sample(s, k == len - 1);
    end
  endtask

  // Send whole rows of random shape and length until n_items samples went out.
  task automatic run_rows(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    row_shape_t  shape;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35)      shape = SHAPE_HILLS;
      else if (pick < 60) shape = SHAPE_ZIGZAG;
      else if (pick < 80) shape = SHAPE_LEVELS;
      else                shape = SHAPE_NOISE;
      pick = $urandom_range(99);
      if (pick < 10)      len = $urandom_range(2, 1);
      else if (pick < 90) len = $urandom_range(24, 3);
      else                len = $urandom_range(60, 25);
      send_row(len, shape);
      sent += len;
    end
  endtask

  // Drop valid and hold until every pending peak result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four thresholds on back-to-back edges. Call only while idle.
  task automatic write_setting(input logic [15:0] height, input logic [15:0] width,
                               input logic [15:0] prom, input logic [15:0] spacing);
    cfg_wr_en <= 1'b1;
    cfg_index <= pfpw_pkg::CFG_MIN_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_index <= pfpw_pkg::CFG_MIN_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= pfpw_pkg::CFG_MIN_PROMINENCE;
    cfg_data  <= prom;
    @(posedge clk);
    cfg_index <= pfpw_pkg::CFG_MIN_SPACING;
    cfg_data  <= spacing;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_row_end      = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = pfpw_pkg::CFG_MIN_HEIGHT;
    cfg_data        = '0;
    hold_req        = 0;
    set_idling(0, 0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset thresholds (spacing 100).
    // Single sample and two samples: too short for any candidate.
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // Peak equal to its right neighbor: a candidate, but prominence is zero.
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // Full-scale peak whose right walk crosses a flat run.
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    // Three peaks two apart: the spacing of 100 keeps only the first.
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd30, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd10, 1'b1);
    drain();
    // Same row with spacing 1: every peak clears the spacing test.
    write_setting(16'd0, 16'd0, 16'd0, 16'd1);
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd30, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd20, 1'b0);
    send_sample(16'd10, 1'b1);
    drain();

    // Random rows. Loosest thresholds, no idling on either side.
    write_setting(16'd0, 16'd0, 16'd0, 16'd0);
    run_rows(50);
    drain();

    // Moderate random thresholds, sender idle about half the time.
    write_setting(16'($urandom_range(2000)), 16'($urandom_range(4)),
                  16'($urandom_range(300)), 16'($urandom_range(8)));
    set_idling(45, 0);
    run_rows(50);
    drain();

    // Height and prominence at their top, width 1024, spacing 1023: nothing passes, every row gives an empty list.
    write_setting(16'hFFFF, 16'd1024, 16'hFFFF, 16'd1023);
    set_idling(0, 45);
    run_rows(35);
    drain();

    // Widest spacing with open thresholds: one peak per row at most.
    write_setting(16'd0, 16'd0, 16'd0, 16'd1023);
    set_idling(36, 36);
    run_rows(40);
    drain();

    write_setting(16'd1000, 16'd4, 16'd500, 16'd10);
    run_rows(40);
    drain();

    // Back-pressure: hold the receiver off while rows keep coming, so the block
    // fills and stalls its input. Then pause until every result is taken.
    write_setting(16'd0, 16'd0, 16'd0, 16'd0);
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    run_rows(35);
    drain();
    set_idling(0, 45);
    run_rows(25);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
